>>> rtl/nps_pkg.sv
// Shared constants, types and the default palette contents
// for the nearest palette color search unit. No dependencies.
package nps_pkg;

  localparam int PALETTE_DEPTH_DEF      = 256;
  localparam int SYSTEM_COLOR_COUNT_DEF = 16;
  localparam int IDX_W                  = 8;
  localparam int COLOR_W                = 24;
  localparam int DIST_W                 = 18;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [255:0][COLOR_W-1:0] palette_rom_t;

  localparam logic [COLOR_W-1:0] SYSTEM_COLORS [16] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
    24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  function automatic logic [7:0] cube_level(int step);
    return (step == 0) ? 8'd0 : 8'(255 - 40 * (5 - step));
  endfunction

  function automatic palette_rom_t build_reset_palette();
    palette_rom_t rom;
    int c;
    int v;
    for (int i = 0; i < 256; i++) begin
      if (i < 16) begin
        rom[i] = SYSTEM_COLORS[i];
      end else if (i < 232) begin
        c = i - 16;
        rom[i] = {cube_level(c % 6), cube_level((c / 6) % 6), cube_level(c / 36)};
      end else begin
        v = 8 + 10 * (i - 232);
        rom[i] = {8'(v), 8'(v), 8'(v)};
      end
    end
    return rom;
  endfunction

  localparam palette_rom_t RESET_PALETTE = build_reset_palette();

endpackage

>>> rtl/nearest_palette_color_search_unit.sv
// Nearest palette color search: palette RAM, one distance unit, scan sequencer.
// Depends on nps_pkg.
//
// A query over N entries (240, or 16 in system mode) streams one entry per
// cycle through the single read port and distance unit. The next item is
// taken once the result is loaded into the output register.
// Synchronous active-low reset restores the default palette through per-entry
// valid bits (no clearing pass) and clears the mode register.
module nearest_palette_color_search_unit #(
  parameter int PALETTE_DEPTH      = nps_pkg::PALETTE_DEPTH_DEF,
  parameter int SYSTEM_COLOR_COUNT = nps_pkg::SYSTEM_COLOR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], rgb_color[31:8]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // nearest_index[7:0]
  input  logic        cfg_wen,
  input  logic        cfg_wdata
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic NONSYS_EMPTY = (SYSTEM_COLOR_COUNT >= PALETTE_DEPTH);
  localparam logic [AW-1:0] SYS_FIRST   = '0;
  localparam logic [AW-1:0] SYS_END     = AW'(SYSTEM_COLOR_COUNT - 1);
  localparam logic [AW-1:0] NONSYS_FIRST = AW'(SYSTEM_COLOR_COUNT % PALETTE_DEPTH);
  localparam logic [AW-1:0] NONSYS_END  = AW'(PALETTE_DEPTH - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t                          state_r;
  logic                            mode_r;
  logic [PALETTE_DEPTH-1:0]        valid_r;
  logic [nps_pkg::COLOR_W-1:0]     mem [PALETTE_DEPTH];
  logic [nps_pkg::COLOR_W-1:0]     mem_q_r;
  logic [nps_pkg::COLOR_W-1:0]     query_r;
  logic [AW-1:0]                   rd_addr_r;
  logic [AW-1:0]                   scan_first_r;
  logic [AW-1:0]                   scan_end_r;
  logic                            s1_v_r, s1_last_r, s1_vld_r;
  logic [AW-1:0]                   s1_idx_r;
  logic                            s2_v_r, s2_last_r;
  logic [AW-1:0]                   s2_idx_r;
  logic [nps_pkg::DIST_W-1:0]      dist_r;
  logic                            found_r;
  logic [nps_pkg::DIST_W-1:0]      best_d_r;
  logic [AW-1:0]                   best_r;
  logic                            out_tvalid_r;
  logic [7:0]                      out_tdata_r;

  logic                            in_acc;
  logic                            mem_we;
  logic [AW-1:0]                   waddr;
  logic [nps_pkg::COLOR_W-1:0]     entry_color;
  logic [nps_pkg::DIST_W-1:0]      dist_nxt;
  logic                            out_free;

  function automatic logic [15:0] sq_diff(logic [7:0] a, logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign waddr      = in_tdata[AW-1:0];
  assign mem_we     = in_acc && (in_tuser == nps_pkg::OP_WRITE)
                      && ({1'b0, in_tdata[7:0]} < 9'(PALETTE_DEPTH));
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign entry_color = s1_vld_r ? mem_q_r : nps_pkg::RESET_PALETTE[8'(s1_idx_r)];
  assign dist_nxt = 18'(sq_diff(entry_color[7:0],   query_r[7:0]))
                  + 18'(sq_diff(entry_color[15:8],  query_r[15:8]))
                  + 18'(sq_diff(entry_color[23:16], query_r[23:16]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_tdata[31:8];
    end
    mem_q_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= 1'b0;
      valid_r      <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      rd_addr_r    <= '0;
      scan_first_r <= '0;
      scan_end_r   <= '0;
      best_r       <= '0;
    end else begin
      if (cfg_wen) begin
        mode_r <= cfg_wdata;
      end
      if (mem_we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      // read stage
      s1_v_r    <= (state_r == ST_SCAN);
      s1_last_r <= (rd_addr_r == scan_end_r);
      s1_idx_r  <= rd_addr_r;
      s1_vld_r  <= valid_r[rd_addr_r];

      // distance stage
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      s2_idx_r  <= s1_idx_r;
      dist_r    <= dist_nxt;

      // compare stage
      if (s2_v_r && (!found_r || dist_r < best_d_r)) begin
        found_r  <= 1'b1;
        best_d_r <= dist_r;
        best_r   <= s2_idx_r;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_tuser == nps_pkg::OP_QUERY) begin
            query_r <= in_tdata[31:8];
            found_r <= 1'b0;
            best_r  <= '0;
            if (mode_r) begin
              rd_addr_r    <= SYS_FIRST;
              scan_first_r <= SYS_FIRST;
              scan_end_r   <= SYS_END;
              state_r      <= ST_SCAN;
            end else begin
              rd_addr_r    <= NONSYS_FIRST;
              scan_first_r <= NONSYS_FIRST;
              scan_end_r   <= NONSYS_END;
              state_r      <= NONSYS_EMPTY ? ST_DONE : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_addr_r == scan_end_r) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_addr_r <= rd_addr_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (s2_v_r && s2_last_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= 8'(best_r);
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!s1_v_r && !s2_v_r))
    else $error("item accepted while scan pipeline busy");

  a_pipe_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("distance stage active outside a scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && found_r) |-> (best_r >= scan_first_r && best_r <= scan_end_r))
    else $error("best index outside searched range");

endmodule
